// ===== design/crc16_pkg.sv =====
// Package: shared types, constants and the byte step function of the CRC-16 engine.
`timescale 1ns / 1ps

package crc16_pkg;

    localparam int unsigned CRC_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IX_W = 2;

    localparam logic [CRC_W-1:0] POLY_RESET  = 16'hA001;
    localparam logic [CRC_W-1:0] START_RESET = 16'hFFFF;

    // Register indexes of the configuration port
    localparam logic [CFG_IX_W-1:0] REG_POLYNOMIAL  = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_START_VALUE = 2'd1;

    // Item commands
    localparam logic CMD_ABSORB  = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Read response of the state memory
    typedef struct packed {
        logic             valid;
        logic [CRC_W-1:0] data;
    } t_mem_rd;

    // Eight reflected shift steps on the table index, LSB first
    function automatic logic [CRC_W-1:0] crc_byte_term(
        input logic [CRC_W-1:0]  poly,
        input logic [BYTE_W-1:0] index
    );
        logic [CRC_W-1:0]  acc;
        logic [BYTE_W-1:0] val;
        acc = '0;
        val = index;
        for (int i = 0; i < BYTE_W; i++) begin
            if (acc[0] ^ val[0]) begin
                acc = (acc >> 1) ^ poly;
            end else begin
                acc = acc >> 1;
            end
            val = val >> 1;
        end
        return acc;
    endfunction

endpackage

// ===== design/crc16_reflected_byte_engine_top.sv =====
// Top level of the reflected CRC-16 byte engine: pipeline control, registers, output stage.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------
//  input    | in        | i_valid / o_stall | i_command, i_data_byte
//  result   | out       | o_valid / i_stall | o_crc_value
//  config   | in        | i_cfg_we          | i_cfg_index, i_cfg_data
//
//  One transaction per cycle sustained while the result channel does not stall; a result
//  passes the update stage (state read) and the output register before o_valid rises.
//  Each byte makes a single read-modify-write of the state memory; a write landing
//  on the edge of the next read is forwarded so back-to-back bytes never wait.
//  Reset (synchronous, active low) restores polynomial 0xA001 and start value 0xFFFF
//  and marks the state entry unwritten, so it reads as 0xFFFF; no clearing pass.
//  A stalled result holds in the output register while one more transaction is taken.
`timescale 1ns / 1ps

module crc16_reflected_byte_engine_top
    import crc16_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_command,
    input  logic [BYTE_W-1:0]   i_data_byte,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CRC_W-1:0]    o_crc_value,
    // configuration port
    input  logic                i_cfg_we,
    input  logic [CFG_IX_W-1:0] i_cfg_index,
    input  logic [CRC_W-1:0]    i_cfg_data
);

    // configuration
    logic [CRC_W-1:0]  r_poly;
    logic [CRC_W-1:0]  r_start;

    // update stage: the transaction whose state read is in flight
    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [BYTE_W-1:0] r_s1_data;

    // forwarding of a write that coincided with the read
    logic              r_byp;
    logic [CRC_W-1:0]  r_byp_crc;

    // output register
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_out_crc;

    t_mem_rd           mem_rd;
    logic              accept;
    logic              s1_adv;
    logic [CRC_W-1:0]  cur_crc;
    logic [CRC_W-1:0]  n_crc;

    // Advance the update stage whenever the output register is free or being drained
    assign s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign accept  = i_valid && !o_stall;

    // Pick the freshest running CRC: forwarded write, then memory, then reset value
    always_comb begin
        if (r_byp) begin
            cur_crc = r_byp_crc;
        end else if (mem_rd.valid) begin
            cur_crc = mem_rd.data;
        end else begin
            cur_crc = START_RESET;
        end
    end

    crc16_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_wr_en   (s1_adv),
        .i_wr_data (n_crc),
        .o_rd      (mem_rd)
    );

    crc16_byte_step u_step (
        .i_command     (r_s1_cmd),
        .i_data_byte   (r_s1_data),
        .i_crc         (cur_crc),
        .i_polynomial  (r_poly),
        .i_start_value (r_start),
        .o_crc         (n_crc)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= POLY_RESET;
            r_start     <= START_RESET;
            r_s1_valid  <= 1'b0;
            r_byp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop writes to indexes beyond the register list
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POLYNOMIAL:  r_poly  <= i_cfg_data;
                    REG_START_VALUE: r_start <= i_cfg_data;
                    default:         ;
                endcase
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_command;
            r_s1_data <= i_data_byte;
            r_byp_crc <= n_crc;
        end
        if (s1_adv) begin
            r_out_crc <= n_crc;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_crc_value = r_out_crc;

endmodule

// ===== design/crc16_state_mem.sv =====
// Single-entry synchronous state memory holding the running CRC, with a registered read.
`timescale 1ns / 1ps

module crc16_state_mem
    import crc16_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic             i_wr_en,
    input  logic [CRC_W-1:0] i_wr_data,
    output t_mem_rd          o_rd
);

    logic [CRC_W-1:0] r_mem [0:0];
    logic             r_mem_valid;
    logic [CRC_W-1:0] r_rd_data;
    logic             r_rd_valid;

    // Payload store: no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[0] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[0];
        end
    end

    // Valid bit: an unwritten entry reads as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_mem_valid <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_mem_valid;
            end
        end
    end

    assign o_rd.valid = r_rd_valid;
    assign o_rd.data  = r_rd_data;

endmodule

// ===== design/crc16_byte_step.sv =====
// Next-state logic: absorb one byte or reload the start value.
`timescale 1ns / 1ps

module crc16_byte_step
    import crc16_pkg::*;
(
    input  logic              i_command,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic [CRC_W-1:0]  i_crc,
    input  logic [CRC_W-1:0]  i_polynomial,
    input  logic [CRC_W-1:0]  i_start_value,
    output logic [CRC_W-1:0]  o_crc
);

    logic [BYTE_W-1:0] index;
    logic [CRC_W-1:0]  term;

    assign index = i_data_byte ^ i_crc[BYTE_W-1:0];
    assign term  = crc_byte_term(i_polynomial, index);

    always_comb begin
        case (i_command)
            CMD_RESTART: o_crc = i_start_value;
            CMD_ABSORB:  o_crc = (i_crc >> BYTE_W) ^ term;
            default:     o_crc = i_crc;
        endcase
    end

endmodule

// ===== design/crc16_checker.sv =====
// Port-level checker for the CRC-16 byte engine, bound to the top level.
`timescale 1ns / 1ps

module crc16_checker
    import crc16_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [CRC_W-1:0]    o_crc_value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_crc_value))
        else $error("stalled result changed or vanished");

    // An empty output register never pushes back on the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output register");

    // Every accepted transaction shows a result after the update stage and output register
    a_result_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 o_valid)
        else $error("result missing two cycles after acceptance");

    // Nothing comes out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind crc16_reflected_byte_engine_top crc16_checker u_crc16_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_crc_value (o_crc_value)
);
